// ===== hw/rtl/odp_pkg.sv =====
// ---------------------------------------------------------------------------
// odp_pkg
// Shared types, codes and reset values for the offscreen detect policy unit.
// ---------------------------------------------------------------------------
package odp_pkg;

    localparam int unsigned MICROS_IN_MILLI = 1000;
    localparam int unsigned MICROS_IN_SEC   = 1000000;

    // field widths fixed by the interface
    localparam int unsigned TIME_W     = 63;
    localparam int unsigned COUNT_IN_W = 16;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned THR_CFG_W  = 16;
    localparam int unsigned MARGIN_W   = 8;

    // default for the count width parameter
    localparam int unsigned COUNT_BITS_DEF = 16;

    // register reset values
    localparam logic [THR_CFG_W-1:0] DEF_THRESHOLD     = 16'd10;
    localparam logic [MARGIN_W-1:0]  DEF_MARGIN        = 8'd2;
    localparam logic [CFG_W-1:0]     DEF_QUERY_IVL_US  = CFG_W'(2000 * MICROS_IN_MILLI);
    localparam logic [CFG_W-1:0]     DEF_FAST_TICK_US  = CFG_W'(3 * MICROS_IN_SEC);
    localparam logic [CFG_W-1:0]     DEF_SLOW_TICK_US  = CFG_W'(15 * MICROS_IN_SEC);
    localparam logic [CFG_W-1:0]     DEF_HEARTBEAT_US  = CFG_W'(60 * MICROS_IN_SEC);
    localparam logic [CFG_W-1:0]     DEF_ACT_WINDOW_US = CFG_W'(10 * MICROS_IN_SEC);
    localparam logic [CFG_W-1:0]     DEF_SILENCE_US    = CFG_W'(90 * MICROS_IN_SEC);

    // input within this long of an unknown verdict means the screen is on, unless a calibrated sample decides
    localparam logic [CFG_W-1:0]     FRESH_INPUT_US    = CFG_W'(1 * MICROS_IN_SEC);

    // event kinds
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_INPUT   = 2'd1,
        OP_VERDICT = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    // verdict codes (anything else is treated as unknown)
    localparam logic [1:0] SCR_ON      = 2'd0;
    localparam logic [1:0] SCR_OFF     = 2'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEF_THRESHOLD = 3'd0,
        REG_MARGIN        = 3'd1,
        REG_QUERY_IVL     = 3'd2,
        REG_FAST_TICK     = 3'd3,
        REG_SLOW_TICK     = 3'd4,
        REG_HEARTBEAT     = 3'd5,
        REG_ACT_WINDOW    = 3'd6,
        REG_SILENCE       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [THR_CFG_W-1:0] base_threshold;
        logic [MARGIN_W-1:0]  band_gap;
        logic [CFG_W-1:0]     query_interval_us;
        logic [CFG_W-1:0]     fast_tick_us;
        logic [CFG_W-1:0]     slow_tick_us;
        logic [CFG_W-1:0]     steady_tick_us;
        logic [CFG_W-1:0]     busy_window_us;
        logic [CFG_W-1:0]     silence_off_us;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            op;
        logic [COUNT_IN_W-1:0] count;
        logic [TIME_W-1:0]     now_us;
        logic [1:0]            screen_state;
    } t_event;

    typedef struct packed {
        logic             query_request;
        logic             publish_change;
        logic             offscreen_value;
        logic [CFG_W-1:0] rearm_tick_us;
    } t_result;

endpackage

// ===== hw/rtl/offscreen_detect_policy_unit.sv =====
// ---------------------------------------------------------------------------
// offscreen_detect_policy_unit
// Screen-off detector: learns on/off count bands and publishes flag changes.
// ---------------------------------------------------------------------------
// Takes one event beat per clock and returns one result beat per event. An
// accepted event sits in an input register; the policy logic decides it and
// updates the detector state as the event leaves that register, and the
// outcome is loaded into a result register at the same edge, from which the
// result beat is offered. Throughput is one event per cycle for as long as the
// result side keeps taking beats. A waiting result holds the event in the input
// register, so the input stalls once both registers are full; with the input
// register empty one more event is still taken. The state loop that sets the
// rate is the detector state update in odp_policy. Configuration is written at
// any edge with i_cfg_we high and should change only while idle.
module offscreen_detect_policy_unit
    import odp_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // events
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [COUNT_IN_W-1:0] i_count,
    input  logic [TIME_W-1:0]     i_now_us,
    input  logic [1:0]            i_screen_state,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_query_request,
    output logic                  o_publish_change,
    output logic                  o_offscreen_value,
    output logic [CFG_W-1:0]      o_rearm_tick_us
);

    t_cfg    w_cfg;
    t_event  r_in;
    t_result r_out, w_res;
    logic    r_in_valid, r_out_valid;
    logic    w_adv;

    odp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // the held event moves on when the result slot is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    odp_policy #(
        .COUNT_BITS (COUNT_BITS)
    ) u_policy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ev    (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.op           <= i_op;
            r_in.count        <= i_count;
            r_in.now_us       <= i_now_us;
            r_in.screen_state <= i_screen_state;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_query_request   = r_out.query_request;
    assign o_publish_change  = r_out.publish_change;
    assign o_offscreen_value = r_out.offscreen_value;
    assign o_rearm_tick_us   = r_out.rearm_tick_us;

endmodule

// ===== hw/rtl/odp_cfg.sv =====
// ---------------------------------------------------------------------------
// odp_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module odp_cfg
    import odp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEF_THRESHOLD: n_cfg.base_threshold    = i_cfg_data[THR_CFG_W-1:0];
                REG_MARGIN:        n_cfg.band_gap          = i_cfg_data[MARGIN_W-1:0];
                REG_QUERY_IVL:     n_cfg.query_interval_us = i_cfg_data;
                REG_FAST_TICK:     n_cfg.fast_tick_us      = i_cfg_data;
                REG_SLOW_TICK:     n_cfg.slow_tick_us      = i_cfg_data;
                REG_HEARTBEAT:     n_cfg.steady_tick_us    = i_cfg_data;
                REG_ACT_WINDOW:    n_cfg.busy_window_us    = i_cfg_data;
                REG_SILENCE:       n_cfg.silence_off_us    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_threshold    <= DEF_THRESHOLD;
            r_cfg.band_gap          <= DEF_MARGIN;
            r_cfg.query_interval_us <= DEF_QUERY_IVL_US;
            r_cfg.fast_tick_us      <= DEF_FAST_TICK_US;
            r_cfg.slow_tick_us      <= DEF_SLOW_TICK_US;
            r_cfg.steady_tick_us    <= DEF_HEARTBEAT_US;
            r_cfg.busy_window_us    <= DEF_ACT_WINDOW_US;
            r_cfg.silence_off_us    <= DEF_SILENCE_US;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/odp_policy.sv =====
// ---------------------------------------------------------------------------
// odp_policy
// Detector state and the single-pass decision logic for one event beat.
// ---------------------------------------------------------------------------
module odp_policy
    import odp_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_event  i_ev,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int unsigned CW = COUNT_BITS;
    localparam int unsigned TW = (CW > THR_CFG_W) ? CW : THR_CFG_W;
    localparam int unsigned MW = ((CW > MARGIN_W) ? CW : MARGIN_W) + 1;

    // elapsed time from then to now below win; time running backwards counts as below
    function automatic logic f_within(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] then,
                                      input logic [CFG_W-1:0]  win);
        logic [TIME_W-1:0] d;
        d = now - then;
        return (now < then) || (d < TIME_W'(win));
    endfunction

    // state
    logic              r_flag, r_cal, r_onv, r_offv, r_sample_valid;
    logic              r_start_valid, r_input_seen, r_act_seen, r_query_seen, r_pending;
    logic [CW-1:0]     r_on_max, r_off_min, r_last_sample;
    logic [TIME_W-1:0] r_start_time, r_lit, r_lat, r_lqt;

    logic              n_flag, n_cal, n_onv, n_offv, n_sample_valid;
    logic              n_start_valid, n_input_seen, n_act_seen, n_query_seen, n_pending;
    logic [CW-1:0]     n_on_max, n_off_min, n_last_sample;
    logic [TIME_W-1:0] n_start_time, n_lit, n_lat, n_lqt;

    logic [TIME_W-1:0] w_now;
    logic [CW-1:0]     w_cnt;
    logic [CW:0]       w_mid_sum;
    logic [TW-1:0]     w_thr;

    // learned band update
    logic              l_clr, l_onv_c, l_offv_c;
    logic              l_onv, l_offv, l_cal;
    logic [CW-1:0]     l_on_max, l_off_min;

    // rate limiter
    logic              w_ask_try, w_ask_bypass, w_ask_ok;

    // unknown verdict
    logic              w_recent, w_silent;
    logic [TIME_W-1:0] w_ref, w_ref_diff;

    assign w_now = i_ev.now_us;
    assign w_cnt = CW'(i_ev.count);

    // working threshold: band midpoint once calibrated
    assign w_mid_sum = {1'b0, r_on_max} + {1'b0, r_off_min};
    assign w_thr     = r_cal ? TW'(w_mid_sum[CW:1]) : TW'(i_cfg.base_threshold);

    // band learning from the last sample under an on or off verdict
    always_comb begin
        l_clr     = 1'b0;
        l_onv_c   = r_onv;
        l_offv_c  = r_offv;
        l_onv     = r_onv;
        l_offv    = r_offv;
        l_on_max  = r_on_max;
        l_off_min = r_off_min;
        if (i_ev.screen_state == SCR_ON) begin
            l_clr    = r_offv && (r_last_sample >= r_off_min);
            l_onv_c  = r_onv && !l_clr;
            l_offv   = r_offv && !l_clr;
            if (!l_onv_c || (r_last_sample > r_on_max)) begin
                l_on_max = r_last_sample;
            end
            l_onv    = 1'b1;
        end else begin
            l_clr    = r_onv && (r_last_sample <= r_on_max);
            l_offv_c = r_offv && !l_clr;
            l_onv    = r_onv && !l_clr;
            if (!l_offv_c || (r_last_sample < r_off_min)) begin
                l_off_min = r_last_sample;
            end
            l_offv   = 1'b1;
        end
        l_cal = l_onv && l_offv &&
                (MW'(l_off_min) > (MW'(l_on_max) + MW'(i_cfg.band_gap)));
    end

    // unknown verdict: a calibrated sample decides, else fresh input means on, long silence means off
    assign w_recent   = r_input_seen && f_within(w_now, r_lit, FRESH_INPUT_US);
    assign w_ref      = r_input_seen ? r_lit : (r_start_valid ? r_start_time : w_now);
    assign w_ref_diff = w_now - w_ref;
    assign w_silent   = (w_now > w_ref) && (w_ref_diff > TIME_W'(i_cfg.silence_off_us));

    // user input skips the rate limit
    assign w_ask_bypass = (t_op'(i_ev.op) == OP_INPUT);

    // verdict request gate
    assign w_ask_ok = !r_pending &&
                      (w_ask_bypass || !r_query_seen ||
                       !f_within(w_now, r_lqt, i_cfg.query_interval_us));

    // event decode and next state
    always_comb begin
        n_flag         = r_flag;
        n_cal          = r_cal;
        n_onv          = r_onv;
        n_offv         = r_offv;
        n_sample_valid = r_sample_valid;
        n_start_valid  = r_start_valid;
        n_input_seen   = r_input_seen;
        n_act_seen     = r_act_seen;
        n_query_seen   = r_query_seen;
        n_pending      = r_pending;
        n_on_max       = r_on_max;
        n_off_min      = r_off_min;
        n_last_sample  = r_last_sample;
        n_start_time   = r_start_time;
        n_lit          = r_lit;
        n_lat          = r_lat;
        n_lqt          = r_lqt;
        w_ask_try      = 1'b0;
        o_res          = '0;

        if (!r_start_valid) begin
            n_start_valid = 1'b1;
            n_start_time  = w_now;
        end

        case (t_op'(i_ev.op))
            OP_SAMPLE: begin
                n_last_sample  = w_cnt;
                n_sample_valid = 1'b1;
                n_lat          = w_now;
                n_act_seen     = 1'b1;
                w_ask_try      = ((TW'(w_cnt) > w_thr) != r_flag) || !r_cal;
            end
            OP_INPUT: begin
                n_lit        = w_now;
                n_input_seen = 1'b1;
                n_lat        = w_now;
                n_act_seen   = 1'b1;
                w_ask_try    = r_flag;
            end
            OP_VERDICT: begin
                if (i_ev.screen_state == SCR_ON || i_ev.screen_state == SCR_OFF) begin
                    n_flag = (i_ev.screen_state == SCR_OFF);
                    if (r_sample_valid) begin
                        n_onv     = l_onv;
                        n_offv    = l_offv;
                        n_on_max  = l_on_max;
                        n_off_min = l_off_min;
                        n_cal     = l_cal;
                    end
                end else if (r_cal && r_sample_valid) begin
                    n_flag = TW'(r_last_sample) > w_thr;
                end else if (w_recent) begin
                    n_flag = 1'b0;
                end else if (w_silent) begin
                    n_flag = 1'b1;
                end
                o_res.publish_change  = (n_flag != r_flag);
                o_res.offscreen_value = (n_flag != r_flag) && n_flag;
            end
            OP_TICK: begin
                w_ask_try = 1'b1;
                if (r_cal) begin
                    o_res.rearm_tick_us = i_cfg.steady_tick_us;
                end else if (r_act_seen && f_within(w_now, r_lat, i_cfg.busy_window_us)) begin
                    o_res.rearm_tick_us = i_cfg.fast_tick_us;
                end else begin
                    o_res.rearm_tick_us = i_cfg.slow_tick_us;
                end
            end
            default: begin
                o_res = '0;
            end
        endcase

        if (w_ask_try && w_ask_ok) begin
            o_res.query_request = 1'b1;
            n_pending           = 1'b1;
            n_query_seen        = 1'b1;
            n_lqt               = w_now;
        end
        // a verdict closes the request in flight
        if (t_op'(i_ev.op) == OP_VERDICT) begin
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag         <= 1'b0;
            r_cal          <= 1'b0;
            r_onv          <= 1'b0;
            r_offv         <= 1'b0;
            r_sample_valid <= 1'b0;
            r_start_valid  <= 1'b0;
            r_input_seen   <= 1'b0;
            r_act_seen     <= 1'b0;
            r_query_seen   <= 1'b0;
            r_pending      <= 1'b0;
            r_on_max       <= '0;
            r_off_min      <= '0;
            r_last_sample  <= '0;
            r_start_time   <= '0;
            r_lit          <= '0;
            r_lat          <= '0;
            r_lqt          <= '0;
        end else if (i_en) begin
            r_flag         <= n_flag;
            r_cal          <= n_cal;
            r_onv          <= n_onv;
            r_offv         <= n_offv;
            r_sample_valid <= n_sample_valid;
            r_start_valid  <= n_start_valid;
            r_input_seen   <= n_input_seen;
            r_act_seen     <= n_act_seen;
            r_query_seen   <= n_query_seen;
            r_pending      <= n_pending;
            r_on_max       <= n_on_max;
            r_off_min      <= n_off_min;
            r_last_sample  <= n_last_sample;
            r_start_time   <= n_start_time;
            r_lit          <= n_lit;
            r_lat          <= n_lat;
            r_lqt          <= n_lqt;
        end
    end

    // calibration needs both bands learnt
    a_cal_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |-> (r_onv && r_offv))
        else $error("calibrated without both bands");

    // an issued request leaves one in flight
    a_req_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.query_request) |=> r_pending)
        else $error("request issued but none pending");

    // a published change is what the flag now holds
    a_pub_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.publish_change) |=> (r_flag == $past(o_res.offscreen_value)))
        else $error("published value differs from flag");

    // only a verdict publishes
    a_pub_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.publish_change |-> (t_op'(i_ev.op) == OP_VERDICT))
        else $error("change published on a non-verdict event");

endmodule
